[hw/rtl/ggs_pkg.sv]
// ----------------------------------------------------------------------------
// ggs_pkg: grid gradient stencil shared types and constants
// Payload structs, register indexes and fixed geometry constants.
// ----------------------------------------------------------------------------
package ggs_pkg;

	localparam int MIN_DIM = 5;   // smallest legal row or column count
	localparam int HALO    = 2;   // stencil half width
	localparam int LAG     = 4;   // first position that completes a stencil

	localparam logic [10:0] COLS_RESET  = 11'd1024;
	localparam logic [15:0] ROWS_RESET  = 16'd1024;
	localparam logic [31:0] SCALE_RESET = 32'd65536;

	typedef enum logic [3:0] {
		CFG_GRID_COLS,
		CFG_GRID_ROWS,
		CFG_INV_RADIAL,
		CFG_INV_VERTICAL
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] radial_disp;
		logic signed [31:0] vertical_disp;
		logic               first_sample;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] radial_d_radial;
		logic signed [31:0] radial_d_vertical;
		logic signed [31:0] vertical_d_radial;
		logic signed [31:0] vertical_d_vertical;
		logic [15:0]        point_row;
		logic [9:0]         point_col;
		logic               grid_done;
	} result_t;

	// one line buffer word: both displacement fields of a grid point
	typedef struct packed {
		logic signed [31:0] vert;
		logic signed [31:0] rad;
	} pair_t;

	typedef struct packed {
		logic        emit;
		logic        done;
		logic [15:0] point_row;
		logic [9:0]  point_col;
	} meta_t;

endpackage

[hw/rtl/ggs_line_bank.sv]
// ----------------------------------------------------------------------------
// ggs_line_bank: one row of line buffer
// Single write port, single registered read port; read returns old data.
// ----------------------------------------------------------------------------
module ggs_line_bank #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   wr_addr,
	input  ggs_pkg::pair_t  wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output ggs_pkg::pair_t  rd_data
);
	import ggs_pkg::*;

	pair_t mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/ggs_stencil.sv]
// ----------------------------------------------------------------------------
// ggs_stencil: fourth-order central difference with fixed-point scaling
// (fm2 - fp2) + 8(fp1 - fm1), times unsigned Q16.16, rounded half away from
// zero and saturated to 32 bits. Seven register stages, shared enable.
// ----------------------------------------------------------------------------
module ggs_stencil (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] fm2,
	input  logic signed [31:0] fm1,
	input  logic signed [31:0] fp1,
	input  logic signed [31:0] fp2,
	input  logic [31:0]        inv,
	output logic signed [31:0] res
);
	import ggs_pkg::*;

	logic [32:0] d1_s2, d2_s2;
	logic [36:0] n_s3;
	logic [36:0] n_neg;
	logic [35:0] m_s4;
	logic        neg_s4, neg_s5, neg_s6, neg_s7;
	logic [51:0] ph_s5, pl_s5, ph_s6;
	logic [51:0] pl_rnd;
	logic [35:0] plr_s6;
	logic [52:0] r_s7;
	logic [31:0] sat;

	assign n_neg  = -n_s3;
	assign pl_rnd = pl_s5 + 52'h8000;

	always_comb begin
		if (neg_s7) begin
			sat = (r_s7 > 53'h0_8000_0000) ? 32'h8000_0000 : -r_s7[31:0];
		end else begin
			sat = (r_s7[52:31] != '0) ? 32'h7FFF_FFFF : r_s7[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s2  <= {fm2[31], fm2} - {fp2[31], fp2};
			d2_s2  <= {fp1[31], fp1} - {fm1[31], fm1};
			n_s3   <= {{4{d1_s2[32]}}, d1_s2} + {d2_s2[32], d2_s2, 3'b000};
			neg_s4 <= n_s3[36];
			m_s4   <= n_s3[36] ? n_neg[35:0] : n_s3[35:0];
			neg_s5 <= neg_s4;
			ph_s5  <= 52'(m_s4) * 52'(inv[31:16]);
			pl_s5  <= 52'(m_s4) * 52'(inv[15:0]);
			neg_s6 <= neg_s5;
			ph_s6  <= ph_s5;
			plr_s6 <= pl_rnd[51:16];
			neg_s7 <= neg_s6;
			r_s7   <= 53'(ph_s6) + 53'(plr_s6);
			res    <= sat;
		end
	end

endmodule

[hw/rtl/grid_gradient_stencil.sv]
// ----------------------------------------------------------------------------
// grid_gradient_stencil: streaming 2D gradient of a displacement grid
// Four line buffer rows per field, radial and vertical fourth-order stencils.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  sample   | sample_valid/ready      | sample_t: two Q8.24 samples, first flag
//  result   | result_valid/ready      | result_t: four derivatives, point, done
//  cfg      | cfg_valid/ready         | cfg_index, cfg_data (ready always high)
//
// One sample per cycle when not stalled; results pass the line buffer read on the
// accepting edge, seven stencil stages and the output register. Reset clears
// position, config, valid flags and vertical delay; line buffers are not cleared.
// Input stalls only when an emitting item reaches the output while the held
// result is not taken; non-emitting items keep flowing.
// ----------------------------------------------------------------------------
module grid_gradient_stencil #(
	parameter int MAX_COLS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  ggs_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_ready,
	output ggs_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [3:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import ggs_pkg::*;

	localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int COLW = $clog2(MAX_COLS + 1);
	localparam int LAST = 8;

	logic [10:0] grid_cols_q;
	logic [15:0] grid_rows_q;
	logic [31:0] inv_r_q, inv_v_q;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	logic [COLW-1:0] cols, c_pre, c_inc;
	logic [15:0]     rows;
	logic [16:0]     r_pre, z_inc;
	logic [CW-1:0]   pos_c, nxt_c;
	logic [15:0]     pos_z, nxt_z;
	logic [31:0]     pc_wide;
	meta_t           meta_in;

	logic adv, sample_acc;
	logic [LAST:1] v_s;
	meta_t meta_s [1:LAST];
	logic [1:0] z_s1;
	pair_t cur_s1;
	pair_t bank_s1 [0:3];
	pair_t r4, r3, r2, r1;
	pair_t sr_q [0:3];
	pair_t vd0_q, vd1_q;
	logic signed [31:0] rr_res, rv_res, vr_res, vv_res;
	result_t result_q;
	logic    result_valid_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= COLS_RESET;
			grid_rows_q <= ROWS_RESET;
			inv_r_q     <= SCALE_RESET;
			inv_v_q     <= SCALE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_COLS:    grid_cols_q <= cfg_data[10:0];
				CFG_GRID_ROWS:    grid_rows_q <= cfg_data[15:0];
				CFG_INV_RADIAL:   inv_r_q     <= cfg_data;
				CFG_INV_VERTICAL: inv_v_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// geometry and position
	always_comb begin
		if (grid_cols_q < 11'(MIN_DIM)) begin
			cols = COLW'(MIN_DIM);
		end else if (32'(grid_cols_q) > 32'(MAX_COLS)) begin
			cols = COLW'(MAX_COLS);
		end else begin
			cols = COLW'(grid_cols_q);
		end
		rows = (grid_rows_q < 16'(MIN_DIM)) ? 16'(MIN_DIM) : grid_rows_q;

		c_pre = sample.first_sample ? '0 : COLW'(col_q);
		r_pre = sample.first_sample ? '0 : {1'b0, row_q};
		if (c_pre >= cols) begin
			c_pre = '0;
			r_pre = r_pre + 17'd1;
		end
		if (r_pre >= {1'b0, rows}) begin
			r_pre = '0;
		end
		pos_c = CW'(c_pre);
		pos_z = r_pre[15:0];

		c_inc = c_pre + COLW'(1);
		z_inc = r_pre + 17'd1;
		if (c_inc >= cols) begin
			nxt_c = '0;
			nxt_z = (z_inc >= {1'b0, rows}) ? 16'd0 : z_inc[15:0];
		end else begin
			nxt_c = CW'(c_inc);
			nxt_z = pos_z;
		end

		pc_wide           = 32'(pos_c) - 32'(HALO);
		meta_in.emit      = (pos_z >= 16'(LAG)) && (c_pre >= COLW'(LAG));
		meta_in.done      = (pos_z == rows - 16'd1) && (c_pre == cols - COLW'(1));
		meta_in.point_row = pos_z - 16'(HALO);
		meta_in.point_col = pc_wide[9:0];
	end

	assign adv = !(v_s[LAST] && meta_s[LAST].emit && result_valid_q && !result_ready);
	assign sample_ready = adv;
	assign sample_acc   = sample_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (sample_acc) begin
			col_q <= nxt_c;
			row_q <= nxt_z;
		end
	end

	// line buffers, one bank per row modulo four
	for (genvar b = 0; b < 4; b++) begin : g_bank
		ggs_line_bank #(
			.DEPTH(MAX_COLS)
		) u_bank (
			.clk    (clk),
			.we     (sample_acc && (pos_z[1:0] == 2'(b))),
			.wr_addr(pos_c),
			.wr_data({sample.vertical_disp, sample.radial_disp}),
			.rd_en  (adv),
			.rd_addr(pos_c),
			.rd_data(bank_s1[b])
		);
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[LAST-1:1], sample_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[1] <= meta_in;
			z_s1      <= pos_z[1:0];
			cur_s1    <= {sample.vertical_disp, sample.radial_disp};
			for (int i = 2; i <= LAST; i++) begin
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	// rows z-4, z-3, z-2, z-1 from the bank rotation
	always_comb begin
		case (z_s1)
			2'd0: begin
				r4 = bank_s1[0]; r3 = bank_s1[1]; r2 = bank_s1[2]; r1 = bank_s1[3];
			end
			2'd1: begin
				r4 = bank_s1[1]; r3 = bank_s1[2]; r2 = bank_s1[3]; r1 = bank_s1[0];
			end
			2'd2: begin
				r4 = bank_s1[2]; r3 = bank_s1[3]; r2 = bank_s1[0]; r1 = bank_s1[1];
			end
			default: begin
				r4 = bank_s1[3]; r3 = bank_s1[0]; r2 = bank_s1[1]; r1 = bank_s1[2];
			end
		endcase
	end

	// centre row history: columns c-1 .. c-4
	always_ff @(posedge clk) begin
		if (adv && v_s[1]) begin
			sr_q[0] <= r2;
			for (int i = 1; i < 4; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	ggs_stencil u_rad_rad (
		.clk(clk), .en(adv),
		.fm2(sr_q[3].rad), .fm1(sr_q[2].rad), .fp1(sr_q[0].rad), .fp2(r2.rad),
		.inv(inv_r_q), .res(rr_res)
	);

	ggs_stencil u_rad_vert (
		.clk(clk), .en(adv),
		.fm2(sr_q[3].vert), .fm1(sr_q[2].vert), .fp1(sr_q[0].vert), .fp2(r2.vert),
		.inv(inv_r_q), .res(rv_res)
	);

	ggs_stencil u_vert_rad (
		.clk(clk), .en(adv),
		.fm2(r4.rad), .fm1(r3.rad), .fp1(r1.rad), .fp2(cur_s1.rad),
		.inv(inv_v_q), .res(vr_res)
	);

	ggs_stencil u_vert_vert (
		.clk(clk), .en(adv),
		.fm2(r4.vert), .fm1(r3.vert), .fp1(r1.vert), .fp2(cur_s1.vert),
		.inv(inv_v_q), .res(vv_res)
	);

	// vertical results lag two beats to line up with the centre column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd0_q <= '0;
			vd1_q <= '0;
		end else if (adv && v_s[LAST]) begin
			vd1_q <= vd0_q;
			vd0_q <= {vv_res, vr_res};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && v_s[LAST] && meta_s[LAST].emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s[LAST] && meta_s[LAST].emit) begin
			result_q.radial_d_radial     <= rr_res;
			result_q.radial_d_vertical   <= rv_res;
			result_q.vertical_d_radial   <= vd1_q.rad;
			result_q.vertical_d_vertical <= vd1_q.vert;
			result_q.point_row           <= meta_s[LAST].point_row;
			result_q.point_col           <= meta_s[LAST].point_col;
			result_q.grid_done           <= meta_s[LAST].done;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |-> (c_pre < cols) && (pos_z < rows))
		else $error("sample position outside grid");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_s[LAST] && meta_s[LAST].emit))
		else $error("result loaded without an emitting item");

	a_done_row: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.grid_done) |-> (result.point_row == rows - 16'd3))
		else $error("grid_done on wrong row");
`endif

endmodule
